[hdl/ris_pkg.sv]
// Shared types, constants and helpers for the record insertion sorter.
// Used by ris_ctrl, ris_datapath and record_insertion_sorter.
`timescale 1ns / 1ps

package ris_pkg;

    localparam int MAX_RECORDS_DEF  = 64;
    localparam int MAX_RECORD_BYTES = 8;
    localparam int REC_W            = 64;
    localparam int LEN_W            = 4;
    localparam int CFG_IDX_W        = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = 2'd1;

    typedef enum logic [0:0] {
        ST_LOAD = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic insert;   // insert the incoming record
        logic emit;     // move the head record into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free; // output register can take a record this cycle
        logic last_one; // only one stored record is left
    } t_status;

    // byte mask for the configured record length, clamped to 1..MAX_RECORD_BYTES
    function automatic logic [REC_W-1:0] len_mask(input logic [LEN_W-1:0] nbytes);
        logic [LEN_W-1:0] n;
        logic [REC_W-1:0] m;
        n = nbytes;
        if (n == LEN_W'(0)) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(MAX_RECORD_BYTES)) begin
            n = LEN_W'(MAX_RECORD_BYTES);
        end
        for (int b = 0; b < REC_W / 8; b++) begin
            m[b*8 +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[hdl/ris_ctrl.sv]
// Controller for the record insertion sorter: load phase and emit phase.
// Depends on ris_pkg for the state, command and status types.
`timescale 1ns / 1ps

module ris_ctrl
    import ris_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.insert = 1'b0;
        o_cmd.emit   = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.insert = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free && i_status.last_one) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

[hdl/ris_datapath.sv]
// Datapath of the record insertion sorter: a row of compare-and-shift cells,
// configuration registers, overflow flag and the output register.
// Depends on ris_pkg for widths, command/status types and the length mask.
`timescale 1ns / 1ps

module ris_datapath
    import ris_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [REC_W-1:0]     i_record,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data,
    input  logic                 i_out_ready,
    output t_status              o_status,
    output logic                 o_out_valid,
    output logic [REC_W-1:0]     o_out_data,
    output logic                 o_out_last,
    output logic                 o_out_ovf
);

    logic                   r_desc;
    logic [LEN_W-1:0]       r_len;
    logic                   r_ovf;
    logic [MAX_RECORDS-1:0] r_valid;
    logic [REC_W-1:0]       r_cell [MAX_RECORDS];
    logic                   r_out_valid;
    logic [REC_W-1:0]       r_out_data;
    logic                   r_out_last;
    logic                   r_out_ovf;

    logic [REC_W-1:0]       w_mask;
    logic [REC_W-1:0]       w_value;
    logic                   w_full;
    logic [MAX_RECORDS-1:0] w_behind;   // stored key goes behind the new one
    logic [MAX_RECORDS-1:0] w_run;      // this cell and all valid cells above move
    logic [MAX_RECORDS-1:0] w_shift;    // valid cell shifts up one place
    logic [MAX_RECORDS-1:0] w_at_end;   // first free cell

    assign w_mask  = len_mask(r_len);
    assign w_value = i_record & w_mask;
    assign w_full  = r_valid[MAX_RECORDS-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
            r_len  <= LEN_W'(MAX_RECORD_BYTES);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DESCENDING:   r_desc <= i_cfg_data[0];
                CFG_RECORD_BYTES: r_len  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // per-cell compare and shift decision
    genvar g;
    generate
        for (g = 0; g < MAX_RECORDS; g++) begin : g_cell
            logic [REC_W-1:0] w_key;
            logic [MAX_RECORDS-1:0] w_mv;
            assign w_key = r_cell[g] & w_mask;
            assign w_behind[g] = r_desc ? (w_key < w_value) : (w_key > w_value);
            // invalid cells never block the run from the top
            assign w_mv = (w_behind & r_valid) | ~r_valid;
            assign w_run[g]   = &w_mv[MAX_RECORDS-1:g];
            assign w_shift[g] = r_valid[g] & w_run[g];
            if (g == 0) begin : g_first
                assign w_at_end[g] = ~r_valid[g];
            end else begin : g_rest
                assign w_at_end[g] = ~r_valid[g] & r_valid[g-1];
            end

            // cell storage: insert shifts up, emit shifts down
            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && !w_full) begin
                    if (g > 0 && w_shift[(g > 0) ? g-1 : 0]) begin
                        r_cell[g] <= r_cell[(g > 0) ? g-1 : 0];
                    end else if (w_shift[g] || w_at_end[g]) begin
                        r_cell[g] <= w_value;
                    end
                end else if (i_cmd.emit && g < MAX_RECORDS-1) begin
                    r_cell[g] <= r_cell[(g < MAX_RECORDS-1) ? g+1 : g];
                end
            end
        end
    endgenerate

    // occupancy and overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.insert) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_valid <= {r_valid[MAX_RECORDS-2:0], 1'b1};
            end
        end else if (i_cmd.emit) begin
            r_valid <= {1'b0, r_valid[MAX_RECORDS-1:1]};
            if (!r_valid[1]) begin
                r_ovf <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= r_cell[0] & w_mask;
            r_out_last <= ~r_valid[1];
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_status.out_free = ~r_out_valid | i_out_ready;
    assign o_status.last_one = ~r_valid[1];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

[hdl/record_insertion_sorter.sv]
// record_insertion_sorter: stable sort of up to MAX_RECORDS records.
// Load: one record per cycle while loading, inserted in the cell row in the cycle it
//   is taken (dropped and overflow set when full). Emit: one result per cycle from
//   the head cell after the final record, while the sink is ready; registered output.
// Reset (synchronous, active low): store empty, overflow clear, ascending, 8 bytes.
`timescale 1ns / 1ps

module record_insertion_sorter
    import ris_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input records
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [REC_W-1:0]     s_axis_tdata,   // [63:0] record
    input  logic                 s_axis_tlast,   // final_record
    // sorted records
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [REC_W-1:0]     m_axis_tdata,   // [63:0] sorted_record
    output logic                 m_axis_tlast,   // end_of_set
    output logic                 m_axis_tuser,   // [0] overflowed
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    ris_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    ris_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_record    (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser)
    );

endmodule

[tb/tb_record_insertion_sorter.sv]
// Self-checking testbench for record_insertion_sorter: drives record sets with random
// stalls on both streams and checks every sorted result against a built-in predictor.
// Depends on ris_pkg and record_insertion_sorter.
`timescale 1ns / 1ps

module tb_record_insertion_sorter;
    import ris_pkg::*;

    localparam int                   CLK_HALF     = 6;
    localparam int                   RESET_CYCLES = 7;
    localparam int                   LONG_HOLD    = 300;
    localparam int                   SETTLE       = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

    // one expected output transfer
    typedef struct {
        logic [REC_W-1:0] rec;
        logic             end_set;
        logic             ovf;
    } t_sorted_result;

    // predictor and result checker
    class t_sort_scoreboard;
        logic [REC_W-1:0] sorted_keys [MAX_RECORDS_DEF];
        int               key_count;
        bit               overflow_seen;
        bit               desc_order;
        logic [LEN_W-1:0] key_bytes;
        t_sorted_result   pending_sorted [$];
        int               errors;
        int               checked;

        function new();
            key_count     = 0;
            overflow_seen = 0;
            desc_order    = 0;
            key_bytes     = LEN_W'(8);
            errors        = 0;
            checked       = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
            case (idx)
                CFG_DESCENDING:   desc_order = data[0];
                CFG_RECORD_BYTES: key_bytes = data;
                default: ;
            endcase
        endfunction

        // significant bytes of a record, length clamped to 1..8
        function logic [REC_W-1:0] key_mask();
            int n;
            n = int'(key_bytes);
            if (n < 1) n = 1;
            if (n > MAX_RECORD_BYTES) n = MAX_RECORD_BYTES;
            if (n >= 8) return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        // stored key shifts up when strictly out of order, so ties keep arrival order
        function bit goes_behind(logic [REC_W-1:0] stored, logic [REC_W-1:0] arriving,
                                 logic [REC_W-1:0] m);
            if (desc_order) return (stored & m) < (arriving & m);
            return (stored & m) > (arriving & m);
        endfunction

        function void note_record(logic [REC_W-1:0] rec, logic last);
            logic [REC_W-1:0] m;
            logic [REC_W-1:0] v;
            int               pos;
            t_sorted_result   r;
            m = key_mask();
            v = rec & m;
            if (key_count >= MAX_RECORDS_DEF) begin
                overflow_seen = 1;
            end else begin
                pos = key_count;
                while (pos > 0 && goes_behind(sorted_keys[pos-1], v, m)) begin
                    sorted_keys[pos] = sorted_keys[pos-1];
                    pos--;
                end
                sorted_keys[pos] = v;
                key_count++;
            end
            // final record flushes the whole set
            if (last) begin
                for (int i = 0; i < key_count; i++) begin
                    r.rec     = sorted_keys[i] & m;
                    r.end_set = (i == key_count - 1);
                    r.ovf     = overflow_seen;
                    pending_sorted.push_back(r);
                end
                key_count     = 0;
                overflow_seen = 0;
            end
        endfunction

        function void check_sorted(logic [REC_W-1:0] data, logic last, logic user);
            t_sorted_result e;
            if (pending_sorted.size() == 0) begin
                $display("%0t: unexpected result data=%h last=%b ovf=%b",
                         $time, data, last, user);
                errors++;
                return;
            end
            e = pending_sorted.pop_front();
            checked++;
            if (data !== e.rec) begin
                $display("%0t: sorted_record expected %h actual %h", $time, e.rec, data);
                errors++;
            end
            if (last !== e.end_set) begin
                $display("%0t: end_of_set expected %b actual %b", $time, e.end_set, last);
                errors++;
            end
            if (user !== e.ovf) begin
                $display("%0t: overflowed expected %b actual %b", $time, e.ovf, user);
                errors++;
            end
        endfunction

        function int pending();
            return pending_sorted.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [REC_W-1:0]     s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [REC_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LEN_W-1:0]     i_cfg_data;

    t_sort_scoreboard sb = new();
    bit               calm;
    bit               press;
    bit               held_long;

    record_insertion_sorter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // monitor: every transfer is seen at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) sb.note_record(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_sorted(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // result sink: random stall bursts, one long hold while the input side is stalled
    initial begin
        int n;
        m_axis_tready = 1'b0;
        held_long     = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held_long && press && s_axis_tvalid && !s_axis_tready) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                held_long = 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_record(input logic [REC_W-1:0] rec, input logic last);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rec;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // registers change only with no set in flight on the output
    task automatic reconfigure(input logic [LEN_W-1:0] desc_data,
                               input logic [LEN_W-1:0] len_data);
        idle_sender();
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if ($urandom_range(0, 2) == 0)
            write_cfg($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                      LEN_W'($urandom_range(0, 15)));
        write_cfg(CFG_DESCENDING, desc_data);
        write_cfg(CFG_RECORD_BYTES, len_data);
    endtask

    // mix of wide random keys, extremes and byte-replicated keys that tie under any length
    function automatic logic [REC_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0:       return 64'($urandom_range(0, 3)) * 64'h0101_0101_0101_0101;
            1:       return '0;
            2:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++) send_record(rand_key(), i == n - 1);
    endtask

    task automatic run_directed();
        // reset defaults: ascending, 8 bytes; lone final record on an empty store
        send_record(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_record(64'h8000_0000_0000_0000, 1'b0);
        send_record(64'h0000_0000_0000_0000, 1'b0);
        send_record(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_record(64'h0000_0000_0000_0001, 1'b0);
        send_record(64'h0000_0000_0000_0005, 1'b0);
        send_record(64'h0000_0000_0000_0005, 1'b0);
        send_record(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        // unused indexes must not disturb anything; descending with upper data bits set
        idle_sender();
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        write_cfg(CFG_UNUSED_2, 4'hF);
        write_cfg(CFG_UNUSED_3, 4'h0);
        write_cfg(CFG_DESCENDING, 4'hF);
        send_record(64'h0123_4567_89AB_CDEF, 1'b0);
        send_record(64'h0000_0000_0000_0000, 1'b0);
        send_record(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_record(64'h8000_0000_0000_0000, 1'b1);
        // one significant byte, ascending
        reconfigure(4'hE, 4'd1);
        send_record(64'h0000_0000_0000_1122, 1'b0);
        send_record(64'hFFFF_FFFF_FFFF_AB03, 1'b0);
        send_record(64'h0000_0000_0000_7701, 1'b1);
        // zero length clamps to one byte, oversize length clamps to eight
        reconfigure(4'h0, 4'd0);
        send_set(2);
        reconfigure(4'h1, 4'd15);
        send_set(2);
        // length shortened while a set is half loaded
        reconfigure(4'h0, 4'd8);
        send_record(64'h00FF_0000_0000_0001, 1'b0);
        send_record(64'h0000_0000_0000_0002, 1'b0);
        reconfigure(4'h0, 4'd2);
        send_record(64'h0000_0000_0000_0003, 1'b1);
    endtask

    task automatic run_random();
        int sent;
        int n;
        int len;
        for (int ph = 0; ph < 5; ph++) begin
            len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            reconfigure(LEN_W'($urandom_range(0, 15)), LEN_W'(len));
            calm = (ph == 4);
            // store fills, a non-final and the final record are both dropped;
            // the sink then holds off while the following sets keep arriving
            if (ph == 1) begin
                press = 1;
                send_set(MAX_RECORDS_DEF + 2);
            end
            sent = 0;
            while (sent < 6) begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                send_set(n);
                sent += n;
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        calm          = 0;
        press         = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random();

        idle_sender();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
